FILE: rtl/generational_handle_allocator_assert.svh
// Assertion macros for the generational handle allocator.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GHA_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GHA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/gha_pkg.sv
// Package: sizes, codes and slot entry layout of the handle allocator.
`timescale 1ns / 1ps
package gha_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int GEN_BITS   = 12;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int PTR_W      = IDX_W + 1;        // can hold SLOT_COUNT (empty mark)
  localparam int HIDX_W     = 10;               // handle index field width
  localparam int HGEN_W     = 12;               // handle generation field width
  localparam int OP_W       = 2;
  localparam int ST_W       = 2;

  localparam logic [PTR_W-1:0] PTR_NONE = PTR_W'(SLOT_COUNT);

  typedef enum logic [OP_W-1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_QUERY   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [GEN_BITS-1:0] gen;
    logic                live;
    logic [PTR_W-1:0]    next;
  } slot_entry_t;

endpackage

FILE: rtl/generational_handle_allocator.sv
// Top level: generational handle allocator with its slot table memory.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries opcode_i, handle_index_i and
//   handle_generation_i. A transfer happens on a rising edge with valid high and
//   stall low. Every input transfer yields exactly one result transfer on the
//   output channel (out_valid_o / out_stall_i) with out_index_o,
//   out_generation_o and status_o.
//   Slot generation, alive mark and free-list link live in one 1024-entry
//   synchronous memory with a registered read. Free-list head and the
//   count of slots taken so far are registers.
//   A create that pops the free list, and a destroy or query of a handle that
//   passes the tag and range checks, read the slot first; the S_LOOK state then
//   writes back the modified entry, if any, and fills the output register. A
//   fresh-slot create, a full create, a rejected handle and clear fill the
//   output register in the cycle after the transfer. Items go one at a time: no
//   new item is taken during the slot read and the write back of the entry.
//   Reset empties the free list and the slot count; the memory is not cleared,
//   since only entries written since reset are ever read. No clearing pass.
//   When the receiver stalls, the result is held in the output register and a
//   new item is taken only once that register drains in the same cycle.
`timescale 1ns / 1ps
module generational_handle_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [gha_pkg::OP_W-1:0]   opcode_i,
  input  logic [gha_pkg::HIDX_W-1:0] handle_index_i,
  input  logic [gha_pkg::HGEN_W-1:0] handle_generation_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [gha_pkg::HIDX_W-1:0] out_index_o,
  output logic [gha_pkg::HGEN_W-1:0] out_generation_o,
  output logic [gha_pkg::ST_W-1:0]   status_o
);
  import gha_pkg::*;

  // Sequencer states.
  localparam logic S_IDLE = 1'b0;   // ready for a transfer
  localparam logic S_LOOK = 1'b1;   // slot read data arrives, modify and write back

  // Slot table.
  slot_entry_t        mem_q [SLOT_COUNT];
  slot_entry_t        rdata_q;
  logic               mem_re, mem_we;
  logic [IDX_W-1:0]   raddr, waddr;
  slot_entry_t        wdata;

  // Control state.
  logic               state_q, state_d;
  logic [PTR_W-1:0]   free_head_q, free_head_d;
  logic [PTR_W-1:0]   used_q, used_d;

  // Item held while the slot read is in flight.
  op_e                op_q, op_d;
  logic [IDX_W-1:0]   addr_q, addr_d;
  logic [HGEN_W-1:0]  tag_q, tag_d;
  logic [HIDX_W-1:0]  hidx_q, hidx_d;

  // Output register.
  logic               out_valid_q, out_valid_d;
  logic [HIDX_W-1:0]  out_index_q, out_index_d;
  logic [HGEN_W-1:0]  out_gen_q, out_gen_d;
  status_e            status_q, status_d;

  logic               in_xfer, out_free;
  op_e                op_in;
  logic [PTR_W-1:0]   idx_ext;
  logic               handle_ok;
  logic               rd_alive;
  logic [GEN_BITS-1:0] gen_bump;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign op_in     = op_e'(opcode_i);
  assign idx_ext   = PTR_W'(handle_index_i);
  // Tag 0 and never-taken slots are rejected before touching the memory.
  assign handle_ok = (handle_generation_i != '0) && (idx_ext < used_q);

  assign rd_alive = rdata_q.live && (HGEN_W'(rdata_q.gen) == tag_q);
  // Generation bump wraps and skips 0.
  assign gen_bump = (rdata_q.gen + GEN_BITS'(1) == '0) ? GEN_BITS'(1)
                                                       : rdata_q.gen + GEN_BITS'(1);

  always_comb begin
    state_d     = state_q;
    free_head_d = free_head_q;
    used_d      = used_q;
    op_d        = op_q;
    addr_d      = addr_q;
    tag_d       = tag_q;
    hidx_d      = hidx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_index_d = out_index_q;
    out_gen_d   = out_gen_q;
    status_d    = status_q;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    raddr       = idx_ext[IDX_W-1:0];
    waddr       = addr_q;
    wdata       = '{gen: GEN_BITS'(1), live: 1'b1, next: PTR_NONE};

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          op_d   = op_in;
          tag_d  = handle_generation_i;
          hidx_d = handle_index_i;
          addr_d = idx_ext[IDX_W-1:0];
          // Default: echo the handle, result straight to the output register.
          out_index_d = handle_index_i;
          out_gen_d   = handle_generation_i;
          status_d    = ST_OK;
          case (op_in)
            OP_CREATE: begin
              if (free_head_q != PTR_NONE) begin
                // Reuse the most recently freed slot: fetch its entry.
                mem_re  = 1'b1;
                raddr   = free_head_q[IDX_W-1:0];
                addr_d  = free_head_q[IDX_W-1:0];
                state_d = S_LOOK;
              end else if (used_q != PTR_NONE) begin
                // Fresh slot, generation 1.
                mem_we      = 1'b1;
                waddr       = used_q[IDX_W-1:0];
                used_d      = used_q + PTR_W'(1);
                out_index_d = HIDX_W'(used_q);
                out_gen_d   = HGEN_W'(1);
                out_valid_d = 1'b1;
              end else begin
                out_index_d = '0;
                out_gen_d   = '0;
                status_d    = ST_FULL;
                out_valid_d = 1'b1;
              end
            end
            OP_DESTROY, OP_QUERY: begin
              if (handle_ok) begin
                mem_re  = 1'b1;
                state_d = S_LOOK;
              end else begin
                status_d    = ST_BAD;
                out_valid_d = 1'b1;
              end
            end
            OP_CLEAR: begin
              used_d      = '0;
              free_head_d = PTR_NONE;
              out_valid_d = 1'b1;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_LOOK: begin
        state_d     = S_IDLE;
        out_valid_d = 1'b1;
        out_index_d = hidx_q;
        out_gen_d   = tag_q;
        status_d    = ST_OK;
        case (op_q)
          OP_CREATE: begin
            mem_we      = 1'b1;
            wdata       = '{gen: rdata_q.gen, live: 1'b1, next: PTR_NONE};
            free_head_d = (rdata_q.next > PTR_NONE) ? PTR_NONE : rdata_q.next;
            out_index_d = HIDX_W'(addr_q);
            out_gen_d   = HGEN_W'(rdata_q.gen);
          end
          OP_DESTROY: begin
            if (rd_alive) begin
              // Retire: bump generation, push slot on the free list.
              mem_we      = 1'b1;
              wdata       = '{gen: gen_bump, live: 1'b0, next: free_head_q};
              free_head_d = PTR_W'(addr_q);
            end else begin
              status_d = ST_BAD;
            end
          end
          default: begin
            status_d = rd_alive ? ST_OK : ST_BAD;
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Slot memory: one write, one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_head_q <= PTR_NONE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    addr_q      <= addr_d;
    tag_q       <= tag_d;
    hidx_q      <= hidx_d;
    out_index_q <= out_index_d;
    out_gen_q   <= out_gen_d;
    status_q    <= status_d;
  end

  assign out_valid_o      = out_valid_q;
  assign out_index_o      = out_index_q;
  assign out_generation_o = out_gen_q;
  assign status_o         = status_q;

  // Checks.
`include "generational_handle_allocator_assert.svh"

  `GHA_ASSERT_NOW(a_look_out_free, clk_i, rst_ni, state_q == S_LOOK, !out_valid_q,
                  "output register busy when slot result lands")
  `GHA_ASSERT_NEXT(a_look_done, clk_i, rst_ni, state_q == S_LOOK,
                   (state_q == S_IDLE) && out_valid_q, "slot lookup did not finish")
  `GHA_ASSERT_NOW(a_head_taken, clk_i, rst_ni, free_head_q != PTR_NONE,
                  free_head_q < used_q, "free-list head beyond taken slots")
  `GHA_ASSERT_NOW(a_used_range, clk_i, rst_ni, state_q == S_LOOK,
                  used_q != '0, "slot lookup with no slot taken")

endmodule
